// ===== rtl/lra_pkg.sv =====
// Shared types for the all-octant line rasterizer.
// No dependencies; used by lra_setup and line_rasterizer_all_octants.
package lra_pkg;

  // Kind of an input word, carried on in_tuser.
  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

endpackage

// ===== rtl/lra_setup.sv =====
// Line setup: octant selection, endpoint ordering and decision terms.
// Depends on lra_pkg (action codes).
module lra_setup #(
  parameter int COORD_BITS = 12
) (
  input  lra_pkg::action_t               action,
  input  logic signed [COORD_BITS-1:0]   x_a,
  input  logic signed [COORD_BITS-1:0]   y_a,
  input  logic signed [COORD_BITS-1:0]   x_b,
  input  logic signed [COORD_BITS-1:0]   y_b,
  output logic                           load,
  output logic                           active,
  output logic                           steep,
  output logic signed [COORD_BITS-1:0]   major_pos,
  output logic signed [COORD_BITS-1:0]   major_end,
  output logic signed [COORD_BITS-1:0]   minor_pos,
  output logic                           minor_down,
  output logic signed [COORD_BITS+2:0]   decision,
  output logic        [COORD_BITS+1:0]   inc_axial,
  output logic signed [COORD_BITS+1:0]   inc_diagonal
);

  localparam int DW = COORD_BITS + 1;

  logic signed [DW-1:0]         diff_x;
  logic signed [DW-1:0]         diff_y;
  logic        [DW-1:0]         dx;
  logic        [DW-1:0]         dy;
  logic        [DW-1:0]         dmaj;
  logic        [DW-1:0]         dmin;
  logic signed [COORD_BITS-1:0] ma, na, mb, nb;

  // A start word loads a new line; step words leave the setup unused.
  assign load = (action == lra_pkg::ACT_START);

  // Absolute deltas on one extra bit so the difference cannot wrap.
  always_comb begin
    diff_x = DW'(x_a) - DW'(x_b);
    diff_y = DW'(y_a) - DW'(y_b);
    dx     = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
    dy     = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
  end

  // Steep lines swap axes; equal deltas keep x as the major axis.
  always_comb begin
    steep = (dy > dx);
    if (steep) begin
      ma = y_a; na = x_a; mb = y_b; nb = x_b; dmaj = dy; dmin = dx;
    end else begin
      ma = x_a; na = y_a; mb = x_b; nb = y_b; dmaj = dx; dmin = dy;
    end
  end

  // Order the endpoints so the major coordinate increases.
  always_comb begin
    if (ma > mb) begin
      major_pos  = mb;
      major_end  = ma;
      minor_pos  = nb;
      minor_down = (nb > na);
    end else begin
      major_pos  = ma;
      major_end  = mb;
      minor_pos  = na;
      minor_down = (na > nb);
    end
    active = (ma != mb);
  end

  // Decision term 2*dmin - dmaj and its two increments.
  always_comb begin
    inc_axial    = {dmin, 1'b0};
    inc_diagonal = (COORD_BITS+2)'({dmin, 1'b0}) - (COORD_BITS+2)'({dmaj, 1'b0});
    decision     = (COORD_BITS+3)'({dmin, 1'b0}) - (COORD_BITS+3)'(dmaj);
  end

endmodule

// ===== rtl/line_rasterizer_all_octants.sv =====
// Top level of the all-octant midpoint line rasterizer: handshakes and stepping.
// Depends on lra_pkg and lra_setup.
//
//  channel | dir | tdata (low bit up)              | side band
//  --------+-----+---------------------------------+------------------------
//  in_     | in  | x_a, y_a, x_b, y_b              | tuser = action
//  out_    | out | pixel_x, pixel_y                | tlast = last_pixel
//
// Each word is captured in an input register and processed from there, so one
// pixel per clock is sustained for step words while the output does not stall;
// the setup or stepping logic from input to result register is combinational.
// A word is processed when the result register is empty or being drained, so
// a stalled output holds one pixel while one more word waits at the input.
// rst_n is synchronous and active low; it clears valid flags and the line.
module line_rasterizer_all_octants #(
  parameter int COORD_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // x_a, y_a, x_b, y_b, then zero fill
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]    in_tdata,
  // action
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // pixel_x, pixel_y, then zero fill
  output logic [((2*COORD_BITS+7)/8)*8-1:0]    out_tdata,
  output logic                                 out_tlast
);

  localparam int C   = COORD_BITS;
  localparam int OW  = ((2*COORD_BITS+7)/8)*8;

  // Input register.
  logic                 in_valid_r;
  lra_pkg::action_t     action_r;
  logic signed [C-1:0]  xa_r, ya_r, xb_r, yb_r;

  // Line state.
  logic                 active_r, active_nxt;
  logic                 steep_r;
  logic signed [C-1:0]  major_pos_r, major_end_r, minor_pos_r;
  logic                 minor_down_r;
  logic signed [C+2:0]  decision_r;
  logic        [C+1:0]  inc_axial_r;
  logic signed [C+1:0]  inc_diagonal_r;

  // Result register.
  logic                 out_valid_r, out_valid_nxt;
  logic signed [C-1:0]  px_r, py_r;
  logic                 last_r;

  // Setup outputs.
  logic                 su_load, su_active, su_steep, su_minor_down;
  logic signed [C-1:0]  su_major_pos, su_major_end, su_minor_pos;
  logic signed [C+2:0]  su_decision;
  logic        [C+1:0]  su_inc_axial;
  logic signed [C+1:0]  su_inc_diagonal;

  // Step datapath.
  logic                 proc;
  logic                 emit;
  logic signed [C+2:0]  dec_step;
  logic signed [C-1:0]  major_step, minor_step;
  logic                 last_step;

  lra_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .action       (action_r),
    .x_a          (xa_r),
    .y_a          (ya_r),
    .x_b          (xb_r),
    .y_b          (yb_r),
    .load         (su_load),
    .active       (su_active),
    .steep        (su_steep),
    .major_pos    (su_major_pos),
    .major_end    (su_major_end),
    .minor_pos    (su_minor_pos),
    .minor_down   (su_minor_down),
    .decision     (su_decision),
    .inc_axial    (su_inc_axial),
    .inc_diagonal (su_inc_diagonal)
  );

  // Process the held word whenever the result slot is free this cycle.
  assign proc      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc;
  assign emit      = proc && !su_load && active_r;

  // One midpoint step along the major axis.
  always_comb begin
    if (decision_r <= 0) begin
      dec_step   = decision_r + (C+3)'(inc_axial_r);
      minor_step = minor_pos_r;
    end else begin
      dec_step   = decision_r + (C+3)'(inc_diagonal_r);
      minor_step = minor_down_r ? minor_pos_r - C'(1) : minor_pos_r + C'(1);
    end
    major_step = major_pos_r + C'(1);
    last_step  = (major_step >= major_end_r);
  end

  // Next control state.
  always_comb begin
    active_nxt = active_r;
    if (proc && su_load) begin
      active_nxt = su_active;
    end else if (emit && last_step) begin
      active_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input word capture.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      action_r <= lra_pkg::action_t'(in_tuser);
      xa_r     <= in_tdata[C-1:0];
      ya_r     <= in_tdata[2*C-1:C];
      xb_r     <= in_tdata[3*C-1:2*C];
      yb_r     <= in_tdata[4*C-1:3*C];
    end
  end

  // Line state: loaded on a start, advanced on each emitted pixel.
  always_ff @(posedge clk) begin
    if (proc && su_load) begin
      steep_r        <= su_steep;
      major_pos_r    <= su_major_pos;
      major_end_r    <= su_major_end;
      minor_pos_r    <= su_minor_pos;
      minor_down_r   <= su_minor_down;
      decision_r     <= su_decision;
      inc_axial_r    <= su_inc_axial;
      inc_diagonal_r <= su_inc_diagonal;
    end else if (emit) begin
      major_pos_r <= major_step;
      minor_pos_r <= minor_step;
      decision_r  <= dec_step;
    end
  end

  // Result word.
  always_ff @(posedge clk) begin
    if (emit) begin
      px_r   <= steep_r ? minor_step : major_step;
      py_r   <= steep_r ? major_step : minor_step;
      last_r <= last_step;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OW'({py_r, px_r});
  assign out_tlast  = last_r;

endmodule
